### sv/rgbhsv_pkg.sv
package rgbhsv_pkg;

   localparam int CH_W      = 8;
   localparam int SAT_REM_W = 8;   // remainder stays below max, at most 255
   localparam int HUE_REM_W = 11;  // remainder stays below 6*(max-min), at most 1530
   localparam int NUM_W     = 12;  // signed hue numerator before the wrap

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // operands of both long divisions, carried down the divider stages
   typedef struct packed {
      logic [SAT_REM_W-1:0] sat_rem;
      logic [CH_W-1:0]      sat_div;
      logic [HUE_REM_W-1:0] hue_rem;
      logic [HUE_REM_W-1:0] hue_div;
      logic [CH_W-1:0]      bri;
   } div_pay_type;

endpackage

### sv/rgbhsv_front.sv
module rgbhsv_front
   import rgbhsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [CH_W-1:0]   in_red,
   input  logic [CH_W-1:0]   in_green,
   input  logic [CH_W-1:0]   in_blue,
   output logic              up_ready,
   output logic              out_valid,
   output div_pay_type       out_pay,
   input  logic              down_ready
);

   // stage 1: max, min and winning channel
   logic              s1_valid_ff, s1_valid_in;
   logic [CH_W-1:0]   s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [CH_W-1:0]   s1_max_ff, s1_max_in;
   logic [CH_W-1:0]   s1_min_ff, s1_min_in;
   sector_type        s1_sect_ff, s1_sect_in;
   logic              s1_ready;

   // stage 2: division operands
   logic              s2_valid_ff, s2_valid_in;
   div_pay_type       s2_pay_ff, s2_pay_in;
   logic              s2_ready;

   logic [CH_W-1:0]        diff;
   logic [HUE_REM_W-1:0]   diff6;
   logic signed [NUM_W-1:0] r_s, g_s, b_s, d_s, num, num_wrap;

   assign s2_ready = !s2_valid_ff || down_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign up_ready = s1_ready;

   always_comb begin
      // red wins ties over green, green over blue
      if (in_red >= in_green && in_red >= in_blue) begin
         s1_sect_in = SECT_RED;
         s1_max_in  = in_red;
      end else if (in_green >= in_blue) begin
         s1_sect_in = SECT_GREEN;
         s1_max_in  = in_green;
      end else begin
         s1_sect_in = SECT_BLUE;
         s1_max_in  = in_blue;
      end
      s1_min_in = in_red;
      if (in_green < s1_min_in) s1_min_in = in_green;
      if (in_blue < s1_min_in)  s1_min_in = in_blue;
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (s1_ready) begin
         s1_red_ff   <= in_red;
         s1_green_ff <= in_green;
         s1_blue_ff  <= in_blue;
         s1_max_ff   <= s1_max_in;
         s1_min_ff   <= s1_min_in;
         s1_sect_ff  <= s1_sect_in;
      end
   end

   always_comb begin
      diff  = s1_max_ff - s1_min_ff;
      diff6 = HUE_REM_W'({diff, 2'b00}) + HUE_REM_W'({diff, 1'b0});
      r_s   = signed'(NUM_W'(s1_red_ff));
      g_s   = signed'(NUM_W'(s1_green_ff));
      b_s   = signed'(NUM_W'(s1_blue_ff));
      d_s   = signed'(NUM_W'(diff));
      case (s1_sect_ff)
         SECT_RED:   num = g_s - b_s;
         SECT_GREEN: num = (d_s <<< 1) + b_s - r_s;
         SECT_BLUE:  num = (d_s <<< 2) + r_s - g_s;
         default:    num = '0;
      endcase
      // negative hue wraps by one full turn
      num_wrap = num;
      if (num < 0) num_wrap = num + signed'(NUM_W'(diff6));

      s2_pay_in.sat_rem = diff;
      s2_pay_in.sat_div = (s1_max_ff == '0) ? CH_W'(1) : s1_max_ff;
      s2_pay_in.hue_rem = num_wrap[HUE_REM_W-1:0];
      s2_pay_in.hue_div = (diff == '0) ? HUE_REM_W'(1) : diff6;
      s2_pay_in.bri     = s1_max_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (s2_ready) begin
         s2_pay_ff <= s2_pay_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_pay   = s2_pay_ff;

endmodule

### sv/rgbhsv_div_step.sv
module rgbhsv_div_step
   import rgbhsv_pkg::*;
#(
   parameter int QW         = 17,
   parameter bit FIRST_STEP = 1'b0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  div_pay_type     in_pay,
   input  logic [QW-1:0]   in_sat_q,
   input  logic [QW-1:0]   in_hue_q,
   output logic            up_ready,
   output logic            out_valid,
   output div_pay_type     out_pay,
   output logic [QW-1:0]   out_sat_q,
   output logic [QW-1:0]   out_hue_q,
   input  logic            down_ready
);

   logic                valid_ff, valid_in;
   div_pay_type         pay_ff, pay_in;
   logic [QW-1:0]       sat_q_ff, sat_q_in, hue_q_ff, hue_q_in;

   logic [SAT_REM_W:0]  sat_work, sat_next;
   logic [HUE_REM_W:0]  hue_work, hue_next;
   logic                sat_bit, hue_bit;

   assign up_ready = !valid_ff || down_ready;

   always_comb begin
      // the first step yields the integer bit, the rest shift in one fraction bit each
      if (FIRST_STEP) begin
         sat_work = {1'b0, in_pay.sat_rem};
         hue_work = {1'b0, in_pay.hue_rem};
      end else begin
         sat_work = {in_pay.sat_rem, 1'b0};
         hue_work = {in_pay.hue_rem, 1'b0};
      end
      sat_bit  = sat_work >= {1'b0, in_pay.sat_div};
      hue_bit  = hue_work >= {1'b0, in_pay.hue_div};
      sat_next = sat_bit ? sat_work - {1'b0, in_pay.sat_div} : sat_work;
      hue_next = hue_bit ? hue_work - {1'b0, in_pay.hue_div} : hue_work;

      pay_in         = in_pay;
      pay_in.sat_rem = sat_next[SAT_REM_W-1:0];
      pay_in.hue_rem = hue_next[HUE_REM_W-1:0];
      sat_q_in       = {in_sat_q[QW-2:0], sat_bit};
      hue_q_in       = {in_hue_q[QW-2:0], hue_bit};
      valid_in       = up_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready) begin
         pay_ff   <= pay_in;
         sat_q_ff <= sat_q_in;
         hue_q_ff <= hue_q_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pay   = pay_ff;
   assign out_sat_q = sat_q_ff;
   assign out_hue_q = hue_q_ff;

endmodule

### sv/rgb_to_hsv_pixel.sv
// rgb_to_hsv_pixel: streaming RGB to hue / saturation / brightness converter
//
// request channel: req_valid with req_red, req_green, req_blue (8 bits each);
//   a beat is taken at a clock edge with req_valid high and req_stall low
// response channel: rsp_valid with rsp_hue (16 bits), rsp_saturation (17 bits)
//   and rsp_brightness (8 bits); a beat is taken when rsp_valid is high and
//   rsp_stall is low; one response beat per request beat, in order
// hue is a fraction of a full turn and saturation a fraction of one, both
//   scaled by 2^FRAC_BITS and truncated; brightness is the largest channel
// pipeline: max/min, then the division operands, then one stage per quotient
//   bit of the two long divisions, which run side by side in the same stages
// throughput: one pixel per clock without a stall; each stage takes a new beat
//   when it is empty or the stage after it moves, so bubbles close up under a stall
// when the receiver stalls, the last stage holds its beat stable and the
//   stall backs up stage by stage; req_stall rises only once every stage is full
// reset (synchronous, active high) empties the pipeline; nothing else is cleared
module rgb_to_hsv_pixel
   import rgbhsv_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [15:0]       rsp_hue,
   output logic [16:0]       rsp_saturation,
   output logic [7:0]        rsp_brightness
);

   // one integer bit plus FRAC_BITS fraction bits, one step each
   localparam int QW    = FRAC_BITS + 1;
   localparam int STEPS = QW;

   div_pay_type   pay   [STEPS+1];
   logic          vld   [STEPS+1];
   logic          rdy   [STEPS+1];
   logic [QW-1:0] sat_q [STEPS+1];
   logic [QW-1:0] hue_q [STEPS+1];
   logic          front_ready;

   // max/min, hue numerator and the divisors
   rgbhsv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_red     (req_red),
      .in_green   (req_green),
      .in_blue    (req_blue),
      .up_ready   (front_ready),
      .out_valid  (vld[0]),
      .out_pay    (pay[0]),
      .down_ready (rdy[0])
   );

   assign req_stall = !front_ready;
   assign sat_q[0]  = '0;
   assign hue_q[0]  = '0;

   // restoring long division, one quotient bit per stage for both quotients
   for (genvar k = 0; k < STEPS; k++) begin : g_div
      rgbhsv_div_step #(
         .QW         (QW),
         .FIRST_STEP (k == 0)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (vld[k]),
         .in_pay     (pay[k]),
         .in_sat_q   (sat_q[k]),
         .in_hue_q   (hue_q[k]),
         .up_ready   (rdy[k]),
         .out_valid  (vld[k+1]),
         .out_pay    (pay[k+1]),
         .out_sat_q  (sat_q[k+1]),
         .out_hue_q  (hue_q[k+1]),
         .down_ready (rdy[k+1])
      );
   end

   // last divider stage doubles as the output register
   assign rdy[STEPS]     = !rsp_stall;
   assign rsp_valid      = vld[STEPS];
   assign rsp_hue        = 16'(hue_q[STEPS]);
   assign rsp_saturation = 17'(sat_q[STEPS]);
   assign rsp_brightness = pay[STEPS].bri;

endmodule
